/* hdl/rhc_pkg.sv */
// ----------------------------------------------------------------------------
// rhc_pkg: shared types, constants and helpers for the RGB/HSV converter
// Holds the channel width, pipeline depths, stage structures and the
// rounding division by the all-ones channel code.
// ----------------------------------------------------------------------------
package rhc_pkg;

    // Channel width; the all-ones code stands for 1.0.
    localparam int CB = 16;

    // Quotient, divisor and numerator widths of the forward divider.
    localparam int QB = CB + 1;
    localparam int DW = CB + 3;
    localparam int NW = 2 * CB + 3;

    // Stage counts behind the input register.
    localparam int FWD_LAT = 2 + QB;
    localparam int INV_LAT = 6;
    localparam int INV_PAD = FWD_LAT - INV_LAT;

    // Configuration port.
    localparam int ADDR_BITS = 3;
    localparam logic REG_DIRECTION = 1'b0;

    localparam logic [CB-1:0] CH_MAX = '1;

    typedef logic [CB-1:0] ch_t;

    typedef enum logic
    {
        DIR_TO_HSV = 1'b0,
        DIR_TO_RGB = 1'b1
    } dir_t;

    // Hue sectors of the inverse conversion.
    typedef enum logic [2:0]
    {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } sector_t;

    // One division request entering the divider.
    typedef struct packed
    {
        logic [NW-1:0] num;
        logic [DW-1:0] den;
    } div_lane_t;

    // Working state of one divider stage.
    typedef struct packed
    {
        logic [NW-1:0] num;
        logic [DW-1:0] den;
        logic [DW-1:0] rem;
        logic [QB-1:0] q;
    } div_st_t;

    // Forward values that travel beside the divider.
    typedef struct packed
    {
        ch_t  v;
        logic zero;
    } fwd_side_t;

    // Three-channel pixel.
    typedef struct packed
    {
        ch_t c1;
        ch_t c2;
        ch_t c3;
    } pix_t;

    // Clamp a value one bit wider than a channel.
    function automatic ch_t sat_ch(input logic [CB:0] x);
        return x[CB] ? CH_MAX : x[CB-1:0];
    endfunction

    // Load a request into the divider's first stage.
    function automatic div_st_t div_init(input div_lane_t l);
        div_st_t s;
        s.num = l.num;
        s.den = l.den;
        s.rem = {{(DW - (NW - QB)){1'b0}}, l.num[NW-1:QB]};
        s.q   = '0;
        return s;
    endfunction

    // One restoring step: bring in the next numerator bit, subtract if it fits.
    function automatic div_st_t div_step(input div_st_t s, input logic nb);
        div_st_t    o;
        logic [DW:0] t;
        logic        ge;
        o   = s;
        t   = {s.rem, nb};
        ge  = (t >= {1'b0, s.den});
        o.rem = ge ? DW'(t - {1'b0, s.den}) : t[DW-1:0];
        o.q   = {s.q[QB-2:0], ge};
        return o;
    endfunction

    // Rounded division of a product by the all-ones code.
    // The estimate is low by at most one; a remainder check corrects it.
    function automatic ch_t div_max_round(input logic [2*CB-1:0] prod);
        logic [2*CB-1:0] y;
        logic [2*CB:0]   s;
        logic [CB:0]     q0;
        logic [2*CB:0]   r;
        logic [CB:0]     q;
        y  = prod + {{(CB + 1){1'b0}}, CH_MAX[CB-1:1]};
        s  = {1'b0, y} + {{(CB + 1){1'b0}}, y[2*CB-1:CB]};
        q0 = s[2*CB:CB];
        r  = {1'b0, y} - {q0, {CB{1'b0}}} + {{CB{1'b0}}, q0};
        q  = (r >= {{(CB + 1){1'b0}}, CH_MAX}) ? q0 + 1'b1 : q0;
        return sat_ch(q);
    endfunction

endpackage

/* hdl/rhc_fwd_prep.sv */
// ----------------------------------------------------------------------------
// rhc_fwd_prep: front end of the RGB to HSV path
// Finds max, min and the hue numerator, then forms both division requests.
// Two register stages.
// ----------------------------------------------------------------------------
module rhc_fwd_prep
    import rhc_pkg::*;
(
    input  logic      clk,
    input  ch_t       red,
    input  ch_t       green,
    input  ch_t       blue,
    output div_lane_t lane_s,
    output div_lane_t lane_h,
    output fwd_side_t side
);

    ch_t           v1_reg;
    ch_t           d1_reg;
    logic [DW-1:0] n1_reg;
    logic          zero1_reg;

    ch_t           mx;
    ch_t           mn;
    ch_t           d;
    logic [DW:0]   d_x;
    logic [DW:0]   n_x;
    logic [DW:0]   six_x;

    div_lane_t     lane_s_reg;
    div_lane_t     lane_h_reg;
    fwd_side_t     side_reg;
    logic [NW-1:0] d_n;

    // Max, min, delta and the sector numerator wrapped into [0, 6*delta).
    always_comb
    begin
        mx = (red > green) ? red : green;
        mn = (red < green) ? red : green;
        if (blue > mx)
        begin
            mx = blue;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        d     = mx - mn;
        d_x   = {{(DW + 1 - CB){1'b0}}, d};
        six_x = (d_x << 2) + (d_x << 1);
        if (red == mx)
        begin
            n_x = {{(DW + 1 - CB){1'b0}}, green} - {{(DW + 1 - CB){1'b0}}, blue};
        end
        else if (green == mx)
        begin
            n_x = (d_x << 1) + {{(DW + 1 - CB){1'b0}}, blue}
                - {{(DW + 1 - CB){1'b0}}, red};
        end
        else
        begin
            n_x = (d_x << 2) + {{(DW + 1 - CB){1'b0}}, red}
                - {{(DW + 1 - CB){1'b0}}, green};
        end
        if (n_x[DW])
        begin
            n_x = n_x + six_x;
        end
    end

    always_ff @(posedge clk)
    begin
        v1_reg    <= mx;
        d1_reg    <= d;
        n1_reg    <= n_x[DW-1:0];
        zero1_reg <= (d == '0);
    end

    // Numerators carry the half-divisor for round half up.
    assign d_n = {{(NW - CB){1'b0}}, d1_reg};

    always_ff @(posedge clk)
    begin
        lane_s_reg.num <= (d_n << CB) - d_n + {{(NW - CB + 1){1'b0}}, v1_reg[CB-1:1]};
        lane_s_reg.den <= {{(DW - CB){1'b0}}, v1_reg};
        lane_h_reg.num <= {n1_reg, {CB{1'b0}}} + (d_n << 1) + d_n;
        lane_h_reg.den <= DW'((d_n << 2) + (d_n << 1));
        side_reg.v     <= v1_reg;
        side_reg.zero  <= zero1_reg;
    end

    assign lane_s = lane_s_reg;
    assign lane_h = lane_h_reg;
    assign side   = side_reg;

endmodule

/* hdl/rhc_div_pipe.sv */
// ----------------------------------------------------------------------------
// rhc_div_pipe: pipelined restoring divider, two lanes
// One quotient bit per stage for saturation and hue; the side values ride
// along so they leave together with the quotients.
// ----------------------------------------------------------------------------
module rhc_div_pipe
    import rhc_pkg::*;
(
    input  logic          clk,
    input  div_lane_t     lane_s,
    input  div_lane_t     lane_h,
    input  fwd_side_t     side_in,
    output logic [QB-1:0] q_s,
    output logic [QB-1:0] q_h,
    output fwd_side_t     side_out
);

    div_st_t   st_s_reg [QB];
    div_st_t   st_h_reg [QB];
    fwd_side_t side_reg [QB];

    // Stage k decides quotient bit QB-1-k.
    for (genvar k = 0; k < QB; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                st_s_reg[k] <= div_step(div_init(lane_s), lane_s.num[QB-1]);
                st_h_reg[k] <= div_step(div_init(lane_h), lane_h.num[QB-1]);
                side_reg[k] <= side_in;
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                st_s_reg[k] <= div_step(st_s_reg[k-1], st_s_reg[k-1].num[QB-1-k]);
                st_h_reg[k] <= div_step(st_h_reg[k-1], st_h_reg[k-1].num[QB-1-k]);
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign q_s      = st_s_reg[QB-1].q;
    assign q_h      = st_h_reg[QB-1].q;
    assign side_out = side_reg[QB-1];

endmodule

/* hdl/rhc_inv_pipe.sv */
// ----------------------------------------------------------------------------
// rhc_inv_pipe: HSV to RGB pipeline
// Sector and fraction, products, rounding, second products, rounding,
// sector select. Six register stages.
// ----------------------------------------------------------------------------
module rhc_inv_pipe
    import rhc_pkg::*;
(
    input  logic clk,
    input  ch_t  hue,
    input  ch_t  sat,
    input  ch_t  val,
    output pix_t rgb
);

    logic [CB+2:0]   p6;

    logic [2:0]      sec1_reg;
    ch_t             f1_reg;
    ch_t             s1_reg;
    ch_t             v1_reg;

    logic [2:0]      sec2_reg;
    ch_t             v2_reg;
    logic [2*CB-1:0] pa2_reg;
    logic [2*CB-1:0] pt2_reg;
    logic [2*CB:0]   pt3_reg;

    logic [2:0]      sec3_reg;
    ch_t             v3_reg;
    ch_t             a3_reg;
    ch_t             t2_3_reg;
    ch_t             t3_3_reg;

    logic [2:0]      sec4_reg;
    ch_t             v4_reg;
    ch_t             a4_reg;
    logic [2*CB-1:0] pb2_4_reg;
    logic [2*CB-1:0] pb3_4_reg;

    logic [2:0]      sec5_reg;
    ch_t             v5_reg;
    ch_t             a5_reg;
    ch_t             b2_5_reg;
    ch_t             b3_5_reg;

    pix_t            rgb_reg;
    logic [2*CB:0]   t2_sum;
    logic [2*CB:0]   t3_sum;

    // Six times hue: the top bits are the sector, the rest the fraction.
    assign p6 = ({3'b000, hue} << 2) + ({3'b000, hue} << 1);

    always_ff @(posedge clk)
    begin
        sec1_reg <= p6[CB+2:CB];
        f1_reg   <= p6[CB-1:0];
        s1_reg   <= sat;
        v1_reg   <= val;
    end

    // Products for the darkest channel and both ramps.
    always_ff @(posedge clk)
    begin
        sec2_reg <= sec1_reg;
        v2_reg   <= v1_reg;
        pa2_reg  <= v1_reg * (CH_MAX - s1_reg);
        pt2_reg  <= s1_reg * f1_reg;
        pt3_reg  <= {{(CB + 1){1'b0}}, s1_reg}
                  * ({1'b1, {CB{1'b0}}} - {1'b0, f1_reg});
    end

    // Round the ramps by the turn and the darkest channel by the full code.
    assign t2_sum = {1'b0, pt2_reg} + {{(CB + 1){1'b0}}, 1'b1, {(CB - 1){1'b0}}};
    assign t3_sum = pt3_reg + {{(CB + 1){1'b0}}, 1'b1, {(CB - 1){1'b0}}};

    always_ff @(posedge clk)
    begin
        sec3_reg <= sec2_reg;
        v3_reg   <= v2_reg;
        a3_reg   <= div_max_round(pa2_reg);
        t2_3_reg <= sat_ch(t2_sum[2*CB:CB]);
        t3_3_reg <= sat_ch(t3_sum[2*CB:CB]);
    end

    always_ff @(posedge clk)
    begin
        sec4_reg  <= sec3_reg;
        v4_reg    <= v3_reg;
        a4_reg    <= a3_reg;
        pb2_4_reg <= v3_reg * (CH_MAX - t2_3_reg);
        pb3_4_reg <= v3_reg * (CH_MAX - t3_3_reg);
    end

    always_ff @(posedge clk)
    begin
        sec5_reg <= sec4_reg;
        v5_reg   <= v4_reg;
        a5_reg   <= a4_reg;
        b2_5_reg <= div_max_round(pb2_4_reg);
        b3_5_reg <= div_max_round(pb3_4_reg);
    end

    // Route the three levels by sector. Zero saturation already gives grey.
    always_ff @(posedge clk)
    begin
        case (sec5_reg)
            SEC_0:   rgb_reg <= '{c1: v5_reg,   c2: b3_5_reg, c3: a5_reg};
            SEC_1:   rgb_reg <= '{c1: b2_5_reg, c2: v5_reg,   c3: a5_reg};
            SEC_2:   rgb_reg <= '{c1: a5_reg,   c2: v5_reg,   c3: b3_5_reg};
            SEC_3:   rgb_reg <= '{c1: a5_reg,   c2: b2_5_reg, c3: v5_reg};
            SEC_4:   rgb_reg <= '{c1: b3_5_reg, c2: a5_reg,   c3: v5_reg};
            default: rgb_reg <= '{c1: v5_reg,   c2: a5_reg,   c3: b2_5_reg};
        endcase
    end

    assign rgb = rgb_reg;

endmodule

/* hdl/rgb_hsv_convert.sv */
// ----------------------------------------------------------------------------
// rgb_hsv_convert: pipelined RGB/HSV color converter
//
//   channel  | signals                                   | handshake
//   ---------+-------------------------------------------+-----------------
//   request  | in_first, in_second, in_third             | start, busy
//   result   | out_first, out_second, out_third          | done strobe
//   config   | psel penable pwrite paddr pwdata prdata   | APB, pready = 1
//
// A request is taken every cycle; busy never rises. The depth from
// acceptance to the done strobe is set by the bit-per-stage divider of
// the forward path; the inverse path is padded to the same depth. Reset
// clears the valid line and selects RGB to HSV.
// The receiver cannot stall, so nothing is held back.
// ----------------------------------------------------------------------------
module rgb_hsv_convert
    import rhc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ch_t                  in_first,
    input  ch_t                  in_second,
    input  ch_t                  in_third,
    output logic                 done,
    output ch_t                  out_first,
    output ch_t                  out_second,
    output ch_t                  out_third,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    dir_t          dir_reg;
    logic          accept;

    logic          v0_reg;
    dir_t          d0_reg;
    pix_t          in0_reg;

    logic          valid_line_reg [FWD_LAT];
    dir_t          dir_line_reg   [FWD_LAT];

    div_lane_t     lane_s;
    div_lane_t     lane_h;
    fwd_side_t     side_pre;
    fwd_side_t     side_post;
    logic [QB-1:0] q_s;
    logic [QB-1:0] q_h;

    pix_t          inv_rgb;
    pix_t          inv_pad_reg [INV_PAD];

    pix_t          fwd_pix;
    pix_t          out_reg;
    logic          done_reg;
    dir_t          out_dir_reg;

    // Configuration register; only the direction bit exists.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= DIR_TO_HSV;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_DIRECTION))
        begin
            dir_reg <= dir_t'(pwdata[0]);
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DIRECTION) ? {31'b0, dir_reg} : 32'b0;

    // Request capture.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        d0_reg  <= dir_reg;
        in0_reg <= '{c1: in_first, c2: in_second, c3: in_third};
    end

    // Valid and direction travel beside the data.
    for (genvar k = 0; k < FWD_LAT; k++)
    begin : g_line
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_line_reg[k] <= 1'b0;
            end
            else
            begin
                valid_line_reg[k] <= (k == 0) ? v0_reg : valid_line_reg[(k == 0) ? 0 : k - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            dir_line_reg[k] <= (k == 0) ? d0_reg : dir_line_reg[(k == 0) ? 0 : k - 1];
        end
    end

    // Forward path: front end then divider.
    rhc_fwd_prep u_fwd_prep
    (
        .clk    (clk),
        .red    (in0_reg.c1),
        .green  (in0_reg.c2),
        .blue   (in0_reg.c3),
        .lane_s (lane_s),
        .lane_h (lane_h),
        .side   (side_pre)
    );

    rhc_div_pipe u_div_pipe
    (
        .clk      (clk),
        .lane_s   (lane_s),
        .lane_h   (lane_h),
        .side_in  (side_pre),
        .q_s      (q_s),
        .q_h      (q_h),
        .side_out (side_post)
    );

    // Inverse path, padded to the forward depth.
    rhc_inv_pipe u_inv_pipe
    (
        .clk (clk),
        .hue (in0_reg.c1),
        .sat (in0_reg.c2),
        .val (in0_reg.c3),
        .rgb (inv_rgb)
    );

    for (genvar k = 0; k < INV_PAD; k++)
    begin : g_pad
        always_ff @(posedge clk)
        begin
            inv_pad_reg[k] <= (k == 0) ? inv_rgb : inv_pad_reg[(k == 0) ? 0 : k - 1];
        end
    end

    // Hue that rounds to a full turn wraps to zero; equal channels give zero.
    always_comb
    begin
        fwd_pix.c3 = side_post.v;
        if (side_post.zero)
        begin
            fwd_pix.c1 = '0;
            fwd_pix.c2 = '0;
        end
        else
        begin
            fwd_pix.c1 = q_h[CB] ? '0 : q_h[CB-1:0];
            fwd_pix.c2 = sat_ch(q_s[CB:0]);
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_line_reg[FWD_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        out_dir_reg <= dir_line_reg[FWD_LAT-1];
        out_reg     <= (dir_line_reg[FWD_LAT-1] == DIR_TO_RGB)
                     ? inv_pad_reg[INV_PAD-1] : fwd_pix;
    end

    assign done       = done_reg;
    assign out_first  = out_reg.c1;
    assign out_second = out_reg.c2;
    assign out_third  = out_reg.c3;

    // Every accepted request comes out at the full pipeline depth.
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(FWD_LAT + 2) done)
        else $error("request did not produce a result on time");

    // No result appears without a request at the matching distance.
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, FWD_LAT + 2))
        else $error("result without a matching request");

    // Forward direction: zero saturation only arises with zero hue.
    a_zero_sat_hue: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (out_dir_reg == DIR_TO_HSV) && (out_second == '0)) |-> (out_first == '0))
        else $error("zero saturation with nonzero hue");

endmodule
